// File: rtl/fbpa_pkg.sv
// Shared types, constants and helpers of the fixed block pool allocator.
package fbpa_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int COUNT_W    = 11;
    localparam int STATUS_W   = 3;
    localparam int PROD_W     = COUNT_W + SIZE_W;
    localparam int STEP_W     = $clog2(IDX_W);
    localparam int CFG_IDX_W  = 2;

    localparam logic [ADDR_W-1:0]  RESET_BASE  = ADDR_W'(65536);
    localparam logic [SIZE_W-1:0]  RESET_SIZE  = SIZE_W'(16);
    localparam logic [COUNT_W-1:0] RESET_COUNT = COUNT_W'(1024);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NULL       = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_MISALIGNED = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_ALL_FREE   = 3'd5;

    localparam logic ACTION_ALLOC = 1'b0;
    localparam logic ACTION_FREE  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   block_address;
        logic [COUNT_W-1:0]  free_count;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP_MUL,
        ST_POP_ADD,
        ST_FREE_CHECK,
        ST_DIV,
        ST_DIV_END
    } state_t;

    typedef struct packed {
        logic                load_req;
        logic                pop;
        logic                mul_count;
        logic                mul_idx;
        logic                div_init;
        logic                div_step;
        logic                push;
        logic                finish;
        logic                give_addr;
        logic [STATUS_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic action;
        logic top_zero;
        logic addr_zero;
        logic outside;
        logic misaligned;
        logic all_free;
        logic div_last;
    } stat_t;

    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] value);
        logic [COUNT_W-1:0] limit;
        limit = COUNT_W'(MAX_BLOCKS);
        return (value > limit) ? limit : value;
    endfunction

endpackage

// File: rtl/fbpa_ctrl.sv
// Controller state machine of the fixed block pool allocator.
module fbpa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  fbpa_pkg::stat_t stat,
    output fbpa_pkg::cmd_t  cmd,
    output logic            busy
);

    fbpa_pkg::state_t state_reg;
    fbpa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbpa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbpa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = fbpa_pkg::ST_DECODE;
                end
            end
            fbpa_pkg::ST_DECODE:
            begin
                if (stat.action == fbpa_pkg::ACTION_FREE)
                begin
                    state_next = fbpa_pkg::ST_FREE_CHECK;
                end
                else if (stat.top_zero)
                begin
                    state_next = fbpa_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = fbpa_pkg::ST_POP_MUL;
                end
            end
            fbpa_pkg::ST_POP_MUL:
            begin
                state_next = fbpa_pkg::ST_POP_ADD;
            end
            fbpa_pkg::ST_POP_ADD:
            begin
                state_next = fbpa_pkg::ST_IDLE;
            end
            fbpa_pkg::ST_FREE_CHECK:
            begin
                if (stat.addr_zero || stat.outside)
                begin
                    state_next = fbpa_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = fbpa_pkg::ST_DIV;
                end
            end
            fbpa_pkg::ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = fbpa_pkg::ST_DIV_END;
                end
            end
            fbpa_pkg::ST_DIV_END:
            begin
                state_next = fbpa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fbpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != fbpa_pkg::ST_IDLE);
        case (state_reg)
            fbpa_pkg::ST_IDLE:
            begin
                cmd.load_req = start;
            end
            fbpa_pkg::ST_DECODE:
            begin
                if (stat.action == fbpa_pkg::ACTION_FREE)
                begin
                    cmd.mul_count = 1'b1;
                end
                else if (stat.top_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = fbpa_pkg::STATUS_EXHAUSTED;
                end
                else
                begin
                    cmd.pop = 1'b1;
                end
            end
            fbpa_pkg::ST_POP_MUL:
            begin
                cmd.mul_idx = 1'b1;
            end
            fbpa_pkg::ST_POP_ADD:
            begin
                cmd.finish    = 1'b1;
                cmd.give_addr = 1'b1;
                cmd.code      = fbpa_pkg::STATUS_OK;
            end
            fbpa_pkg::ST_FREE_CHECK:
            begin
                if (stat.addr_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = fbpa_pkg::STATUS_NULL;
                end
                else if (stat.outside)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = fbpa_pkg::STATUS_OUTSIDE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                end
            end
            fbpa_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            fbpa_pkg::ST_DIV_END:
            begin
                cmd.finish = 1'b1;
                if (stat.misaligned)
                begin
                    cmd.code = fbpa_pkg::STATUS_MISALIGNED;
                end
                else if (stat.all_free)
                begin
                    cmd.code = fbpa_pkg::STATUS_ALL_FREE;
                end
                else
                begin
                    cmd.push = 1'b1;
                    cmd.code = fbpa_pkg::STATUS_OK;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/fbpa_datapath.sv
// Datapath of the fixed block pool allocator: registers, free stack, multiplier and divider.
module fbpa_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fbpa_pkg::request_t                 request,
    input  fbpa_pkg::cmd_t                     cmd,
    input  logic                               cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]        cfg_data,
    output fbpa_pkg::stat_t                    stat,
    output fbpa_pkg::result_t                  result,
    output logic                               done
);

    localparam int AW = fbpa_pkg::ADDR_W;
    localparam int CW = fbpa_pkg::COUNT_W;
    localparam int IW = fbpa_pkg::IDX_W;
    localparam int PW = fbpa_pkg::PROD_W;
    localparam int SW = fbpa_pkg::SIZE_W;

    logic [AW-1:0]              base_reg;
    logic [SW-1:0]              size_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              top_reg;
    logic [CW-1:0]              top_next;
    logic [CW-1:0]              low_reg;
    logic [CW-1:0]              low_next;
    logic                       action_reg;
    logic [AW-1:0]              addr_reg;
    logic [PW-1:0]              prod_reg;
    logic [PW-1:0]              rem_reg;
    logic [IW-1:0]              quot_reg;
    logic [fbpa_pkg::STEP_W-1:0] step_reg;
    logic [IW-1:0]              rd_data_reg;
    logic [IW-1:0]              rd_pos_reg;
    logic                       rd_hit_reg;
    fbpa_pkg::result_t          result_reg;
    logic                       done_reg;

    logic [IW-1:0]              stack_mem [fbpa_pkg::MAX_BLOCKS];

    logic                       reinit;
    logic [CW-1:0]              new_count;
    logic [CW-1:0]              pop_full;
    logic [IW-1:0]              pop_pos;
    logic [IW-1:0]              pop_idx;
    logic [CW-1:0]              mul_a;
    logic [PW-1:0]              trial;
    logic                       trial_ge;
    logic [AW:0]                range_end;
    logic [AW-1:0]              offset;
    logic [CW-1:0]              res_count;

    assign reinit    = cfg_we && (cfg_index == fbpa_pkg::CFG_BASE ||
                                  cfg_index == fbpa_pkg::CFG_SIZE ||
                                  cfg_index == fbpa_pkg::CFG_COUNT);
    assign new_count = (cfg_index == fbpa_pkg::CFG_COUNT) ?
                       fbpa_pkg::eff_count(cfg_data[CW-1:0]) : count_reg;
    assign pop_full  = top_reg - CW'(1);
    assign pop_pos   = pop_full[IW-1:0];
    assign pop_idx   = rd_hit_reg ? rd_data_reg : rd_pos_reg;
    assign mul_a     = cmd.mul_count ? count_reg : CW'(pop_idx);
    assign trial     = PW'(size_reg) << step_reg;
    assign trial_ge  = (rem_reg >= trial);
    assign range_end = {1'b0, base_reg} + (AW + 1)'(prod_reg);
    assign offset    = addr_reg - base_reg;
    assign res_count = cmd.push ? top_reg + CW'(1) : top_reg;

    // Entries below the lowest stack top seen since reinitialization were never
    // written, so the position itself stands in for their content.
    always_comb
    begin
        top_next = top_reg;
        low_next = low_reg;
        if (reinit)
        begin
            top_next = new_count;
            low_next = new_count;
        end
        else if (cmd.pop)
        begin
            top_next = pop_full;
            if (pop_full < low_reg)
            begin
                low_next = pop_full;
            end
        end
        else if (cmd.push)
        begin
            top_next = res_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= fbpa_pkg::RESET_BASE;
            size_reg  <= fbpa_pkg::RESET_SIZE;
            count_reg <= fbpa_pkg::eff_count(fbpa_pkg::RESET_COUNT);
            top_reg   <= fbpa_pkg::eff_count(fbpa_pkg::RESET_COUNT);
            low_reg   <= fbpa_pkg::eff_count(fbpa_pkg::RESET_COUNT);
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            top_reg  <= top_next;
            low_reg  <= low_next;
            done_reg <= cmd.finish;
            if (cfg_we && cfg_index == fbpa_pkg::CFG_BASE)
            begin
                base_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == fbpa_pkg::CFG_SIZE)
            begin
                size_reg <= cfg_data[SW-1:0];
            end
            if (cfg_we && cfg_index == fbpa_pkg::CFG_COUNT)
            begin
                count_reg <= new_count;
            end
            if (cmd.div_init)
            begin
                step_reg <= fbpa_pkg::STEP_W'(IW - 1);
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg - fbpa_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            action_reg <= request.action;
            addr_reg   <= request.address;
        end
        if (cmd.mul_count || cmd.mul_idx)
        begin
            prod_reg <= PW'(mul_a * size_reg);
        end
        if (cmd.div_init)
        begin
            rem_reg  <= offset[PW-1:0];
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (trial_ge)
            begin
                rem_reg <= rem_reg - trial;
            end
            quot_reg <= {quot_reg[IW-2:0], trial_ge};
        end
        if (cmd.pop)
        begin
            rd_pos_reg <= pop_pos;
            rd_hit_reg <= (pop_full >= low_reg);
        end
        if (cmd.finish)
        begin
            result_reg.status        <= cmd.code;
            result_reg.block_address <= cmd.give_addr ? base_reg + AW'(prod_reg) : '0;
            result_reg.free_count    <= res_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[top_reg[IW-1:0]] <= quot_reg;
        end
        rd_data_reg <= stack_mem[pop_pos];
    end

    assign stat.action     = action_reg;
    assign stat.top_zero   = (top_reg == '0);
    assign stat.addr_zero  = (addr_reg == '0);
    assign stat.outside    = (addr_reg < base_reg) || ({1'b0, addr_reg} >= range_end) ||
                             (size_reg == '0);
    assign stat.misaligned = (rem_reg != '0);
    assign stat.all_free   = (top_reg >= count_reg);
    assign stat.div_last   = (step_reg == '0);

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// File: rtl/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator.
//
// Requests enter on start/request and are accepted when start is high and busy
// is low. Each transaction returns exactly one result, shown on result for one
// cycle with done high; the receiver cannot stall it.
// An allocate reads the free stack, then does one multiply and one add before
// done rises; when the pool is exhausted it finishes at the decode instead.
// A free raises done once the divider, after the range check, has found the
// block index and the alignment remainder one quotient bit per cycle (10 steps).
// Null and outside-pool frees raise done at the range check, without the divider.
// One transaction is in flight at a time; the next may be accepted in the cycle
// done is high.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is low while a transaction is in progress or being started. Any
// write to a defined register marks every block free again in the identity
// order.
// After reset the pool is base 65536, block size 16, 1024 blocks, all free;
// no clearing pass over the stack memory is needed.
module fixed_block_pool_allocator_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  fbpa_pkg::request_t             request,
    output logic                           busy,
    output logic                           done,
    output fbpa_pkg::result_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data
);

    fbpa_pkg::cmd_t  cmd;
    fbpa_pkg::stat_t stat;
    logic            cfg_we;

    assign cfg_ready = ~busy & ~start;
    assign cfg_we    = cfg_valid & cfg_ready;

    fbpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    fbpa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .result    (result),
        .done      (done)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a transaction is in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start");

    a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != fbpa_pkg::STATUS_OK) |-> (result.block_address == '0))
        else $error("failed request returned a block address");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.free_count <= fbpa_pkg::COUNT_W'(fbpa_pkg::MAX_BLOCKS)))
        else $error("free count above pool depth");

endmodule
